FILE: hdl/rsa_me_pkg.sv
// shared constants for the rsa modular exponentiation block
package rsa_me_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_PUBLIC_EXP  = 2'd1,
    CFG_PRIVATE_EXP = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  // command codes carried on tuser
  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } command_t;

  // register reset values (toy primes 5 and 11)
  localparam int MODULUS_RST     = 55;
  localparam int PUBLIC_EXP_RST  = 3;
  localparam int PRIVATE_EXP_RST = 27;

endpackage

FILE: hdl/rsa_me_modstep.sv
// one step of shift-and-add modular reduction: (2*acc + cin [+ addend]) mod m
module rsa_me_modstep #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] acc,
  input  logic             cin,
  input  logic             add_en,
  input  logic [WIDTH-1:0] addend,
  input  logic [WIDTH-1:0] modulus,
  output logic [WIDTH-1:0] res
);

  logic [WIDTH:0] dbl;
  logic [WIDTH:0] mod_ext;
  logic [WIDTH:0] dbl_red;
  logic [WIDTH:0] sum;
  logic [WIDTH:0] sum_red;

  // acc < m, so 2*acc + cin < 2m and one subtract is enough
  assign mod_ext = {1'b0, modulus};
  assign dbl     = {acc, cin};
  assign dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;

  // addend < m, same bound holds
  assign sum     = {1'b0, dbl_red[WIDTH-1:0]} + {1'b0, addend};
  assign sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;

  assign res = add_en ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];

endmodule

FILE: hdl/rsa_modular_exponentiation.sv
// top level of the rsa modular exponentiation block
//
// usage: each input transaction carries a value on in_tdata and a command on
// in_tuser (0 encrypt with the public exponent, 1 decrypt with the private
// exponent). one output transaction returns value^exponent mod modulus on
// out_tdata. modulus and both exponents are written over the cfg_ channel
// (index 0 modulus, 1 public exponent, 2 private exponent, 3 ignored), by
// the user only while idle, unenforced by the block; cfg_ready is always high.
// operation: the value is first reduced bit by bit, then each of the WIDTH
// exponent bits costs a modular square plus, for a one bit, a modular
// multiply. every step is one pass through the single shared modstep unit
// (double, conditional add, two reductions). a modulus of 0 or 1 gives 0.
// one item is worked on at a time; in_tready is high only when idle.
// the result sits in an output register, so a new item is taken while it
// waits; if the receiver still stalls when the next result is done, the
// sequencer holds it and waits.
// reset (rst_n low, synchronous) restores modulus 55, exponents 3 and 27,
// clears the sequencer and drops out_tvalid.
module rsa_modular_exponentiation
  import rsa_me_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]    in_tdata,   // message_value, zero padded
  input  logic                          in_tuser,   // command
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [((WIDTH+7)/8)*8-1:0]    out_tdata,  // result_value, zero padded
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [WIDTH-1:0]              cfg_data
);

  localparam int DATA_W = ((WIDTH + 7) / 8) * 8;
  localparam int CNT_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_SQUARE,
    S_MULT,
    S_HOLD
  } state_t;

  state_t             state_r;
  logic [WIDTH-1:0]   modulus_r;
  logic [WIDTH-1:0]   pub_exp_r;
  logic [WIDTH-1:0]   priv_exp_r;
  logic [WIDTH-1:0]   base_r;      // value mod m
  logic [WIDTH-1:0]   acc_r;       // running power
  logic [WIDTH-1:0]   prod_r;      // partial product / remainder
  logic [WIDTH-1:0]   mul_b_r;     // multiplier bits, msb first
  logic [WIDTH-1:0]   exp_r;       // exponent bits, msb first
  logic [CNT_W-1:0]   step_cnt_r;
  logic [CNT_W-1:0]   bit_cnt_r;
  logic               out_valid_r;
  logic [WIDTH-1:0]   out_value_r;

  // shared unit hookup
  logic               unit_cin;
  logic               unit_add;
  logic [WIDTH-1:0]   unit_addend;
  logic [WIDTH-1:0]   unit_res;

  logic               in_fire;
  logic               out_fire;
  logic               step_last;
  logic               modulus_trivial;
  logic               result_load;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_fire   = out_valid_r & out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_value_r);
  assign cfg_ready  = 1'b1;

  assign step_last       = (step_cnt_r == '0);
  assign modulus_trivial = (modulus_r <= WIDTH'(1));

  // finished result moves out once the output register is free
  assign result_load = (state_r == S_HOLD) && (!out_valid_r || out_tready);

  // reduction shifts the value in as carry; multiply phases add on a one bit
  always_comb begin
    unit_cin    = 1'b0;
    unit_add    = 1'b0;
    unit_addend = acc_r;
    unique case (state_r)
      S_REDUCE: unit_cin = mul_b_r[WIDTH-1];
      S_SQUARE: begin
        unit_add    = mul_b_r[WIDTH-1];
        unit_addend = acc_r;
      end
      S_MULT: begin
        // multiplier bits are the base, the running power is added
        unit_add    = mul_b_r[WIDTH-1];
        unit_addend = acc_r;
      end
      default: begin
        unit_cin = 1'b0;
      end
    endcase
  end

  rsa_me_modstep #(
    .WIDTH(WIDTH)
  ) u_modstep (
    .acc     (prod_r),
    .cin     (unit_cin),
    .add_en  (unit_add),
    .addend  (unit_addend),
    .modulus (modulus_r),
    .res     (unit_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WIDTH'(MODULUS_RST);
      pub_exp_r  <= WIDTH'(PUBLIC_EXP_RST);
      priv_exp_r <= WIDTH'(PRIVATE_EXP_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MODULUS:     modulus_r  <= cfg_data;
        CFG_PUBLIC_EXP:  pub_exp_r  <= cfg_data;
        CFG_PRIVATE_EXP: priv_exp_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // set by a finished item, cleared once the receiver takes it
      out_valid_r <= result_load | (out_valid_r & ~out_fire);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mul_b_r    <= in_tdata[WIDTH-1:0];
            prod_r     <= '0;
            step_cnt_r <= CNT_W'(WIDTH - 1);
            bit_cnt_r  <= CNT_W'(WIDTH - 1);
            exp_r      <= (command_t'(in_tuser) == CMD_DECRYPT) ? priv_exp_r : pub_exp_r;
            if (modulus_trivial) begin
              // no nonzero residue exists
              acc_r   <= '0;
              state_r <= S_HOLD;
            end else begin
              acc_r   <= WIDTH'(1);
              state_r <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (step_last) begin
            base_r     <= unit_res;
            mul_b_r    <= acc_r;
            prod_r     <= '0;
            step_cnt_r <= CNT_W'(WIDTH - 1);
            state_r    <= S_SQUARE;
          end else begin
            step_cnt_r <= step_cnt_r - 1'b1;
            mul_b_r    <= mul_b_r << 1;
            prod_r     <= unit_res;
          end
        end
        S_SQUARE, S_MULT: begin
          if (step_last) begin
            acc_r      <= unit_res;
            prod_r     <= '0;
            step_cnt_r <= CNT_W'(WIDTH - 1);
            if (state_r == S_SQUARE && exp_r[WIDTH-1]) begin
              // one bit: multiply by the base
              mul_b_r <= base_r;
              state_r <= S_MULT;
            end else begin
              exp_r   <= exp_r << 1;
              mul_b_r <= unit_res;
              if (bit_cnt_r == '0) begin
                state_r <= S_HOLD;
              end else begin
                bit_cnt_r <= bit_cnt_r - 1'b1;
                state_r   <= S_SQUARE;
              end
            end
          end else begin
            step_cnt_r <= step_cnt_r - 1'b1;
            mul_b_r    <= mul_b_r << 1;
            prod_r     <= unit_res;
          end
        end
        S_HOLD: begin
          // wait until the output register is free
          if (result_load) begin
            out_value_r <= acc_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
